// ===== rtl/core/subscription_slot_table_assert.svh =====
// assertion macros used by the subscription slot table rtl
`ifndef SUBSCRIPTION_SLOT_TABLE_ASSERT_SVH
`define SUBSCRIPTION_SLOT_TABLE_ASSERT_SVH

// same-cycle implication
`define SST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sst_pkg.sv =====
// types, constants and helper functions of the subscription slot table
package sst_pkg;

   localparam int SUB_SLOTS   = 8;
   localparam int ITEM_SLOTS  = 64;
   localparam int SUB_IDX_W   = $clog2(SUB_SLOTS);
   localparam int ITEM_IDX_W  = $clog2(ITEM_SLOTS);
   localparam int ITEM_CNT_W  = ITEM_IDX_W + 1;
   localparam int TRY_W       = $clog2(ITEM_SLOTS + 2);
   localparam int SLOT_W      = 6;
   localparam int KA_W        = 31;
   localparam logic [KA_W-1:0] KA_MAX = 31'h5555_5555;

   // command queue between intake and engine
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);

   // command codes
   localparam logic [2:0] CMD_CREATE   = 3'd0;
   localparam logic [2:0] CMD_FIND     = 3'd1;
   localparam logic [2:0] CMD_DEL_SUB  = 3'd2;
   localparam logic [2:0] CMD_ALLOC    = 3'd3;
   localparam logic [2:0] CMD_DEL_ITEM = 3'd4;

   // status codes
   localparam logic [2:0] STAT_GOOD           = 3'd0;
   localparam logic [2:0] STAT_TOO_MANY_SUBS  = 3'd1;
   localparam logic [2:0] STAT_TOO_MANY_ITEMS = 3'd2;
   localparam logic [2:0] STAT_BAD_SUB        = 3'd3;
   localparam logic [2:0] STAT_BAD_ITEM       = 3'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] session_no;
      logic [31:0] sub_no;
      logic [31:0] item_id;
      logic [31:0] publish_interval;
      logic [31:0] requested_lifetime;
      logic [31:0] requested_keep_alive;
      logic [31:0] notify_limit;
      logic [7:0]  service_priority;
      logic        publish_enable;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [SLOT_W-1:0] slot_index;
      logic [31:0]      assigned_id;
      logic [KA_W-1:0]  ka_granted;
      logic [31:0]      lifetime_granted;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_FIND,
      OP_DEL_SUB,
      OP_ALLOC,
      OP_DEL_ITEM,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } work_type;

   typedef struct packed {
      logic [31:0]     ident;
      logic [31:0]     session;
      logic [31:0]     interval;
      logic [KA_W-1:0] keep_alive;
      logic [31:0]     lifetime;
      logic [31:0]     notify_limit;
      logic [7:0]      prio;
      logic            publish_on;
      logic [31:0]     seq_num;
      logic [63:0]     next_publish;
   } sub_rec_type;

   typedef struct packed {
      logic [31:0] owner;
      logic [31:0] ident;
   } item_ent_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUB_DRAW,
      ST_FREE,
      ST_DRAW,
      ST_SCAN
   } st_type;

   // candidate drawn from a generator, zero skipped
   function automatic logic [31:0] id_first(input logic [31:0] gen);
      return (gen == 32'd0) ? 32'd1 : gen;
   endfunction

   // generator value after one draw
   function automatic logic [31:0] id_advance(input logic [31:0] gen);
      logic [31:0] nxt;
      nxt = id_first(gen) + 32'd1;
      return (nxt == 32'd0) ? 32'd1 : nxt;
   endfunction

   function automatic logic [KA_W-1:0] clamp_ka(input logic [31:0] ka);
      logic [KA_W-1:0] res;
      if (ka == 32'd0) begin
         res = KA_W'(1);
      end else if (ka > {1'b0, KA_MAX}) begin
         res = KA_MAX;
      end else begin
         res = ka[KA_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] raise_lt(input logic [31:0] lt,
                                            input logic [KA_W-1:0] ka);
      logic [31:0] ka3;
      ka3 = {1'b0, ka} + {ka, 1'b0};
      return (lt < ka3) ? ka3 : lt;
   endfunction

endpackage

// ===== rtl/core/sst_front.sv =====
// request intake: accepts, classifies and queues commands for the engine
module sst_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sst_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output sst_pkg::work_type q_data
);
   import sst_pkg::*;

   work_type          ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;
   work_type          cls;
   logic              push, pop;

   always_comb begin
      cls.req = req_data;
      unique case (req_data.cmd)
         CMD_CREATE:   cls.op = OP_CREATE;
         CMD_FIND:     cls.op = OP_FIND;
         CMD_DEL_SUB:  cls.op = OP_DEL_SUB;
         CMD_ALLOC:    cls.op = OP_ALLOC;
         CMD_DEL_ITEM: cls.op = OP_DEL_ITEM;
         default:      cls.op = OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != (Q_PTR_W+1)'(Q_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/sst_back.sv =====
// command engine: subscription table, item memory, id generators, result register
module sst_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  sst_pkg::work_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sst_pkg::rsp_type  rsp_data
);
   import sst_pkg::*;

   st_type                  state_ff, state_in;
   work_type                cur_ff;
   logic [SUB_SLOTS-1:0]    sub_valid_ff, sub_valid_in;
   sub_rec_type             sub_rec_ff [SUB_SLOTS];
   logic [ITEM_SLOTS-1:0]   item_valid_ff, item_valid_in;
   item_ent_type            item_mem [ITEM_SLOTS];
   logic [31:0]             gen_sub_ff, gen_sub_in;
   logic [31:0]             gen_item_ff, gen_item_in;
   logic [TRY_W-1:0]        try_ff, try_in;
   logic [ITEM_CNT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                    rd_live_ff, rd_live_in;
   logic [ITEM_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   item_ent_type            rd_data_ff;
   logic [31:0]             cand_ff, cand_in;
   logic [ITEM_IDX_W-1:0]   free_item_ff, free_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_load;
   logic                    sub_we;
   sub_rec_type             sub_wd;
   logic                    mem_we;
   item_ent_type            mem_wd;

   logic                    out_free;
   logic                    sub_free_any, sub_match_any, sub_taken;
   logic [SUB_IDX_W-1:0]    sub_free_idx, sub_match_idx;
   logic [31:0]             sub_cand;
   logic                    rd_v, own_eq, hit_alloc, hit_purge, hit_del, scan_last;
   logic                    free_here, free_last;
   logic [KA_W-1:0]         ka_rev;
   logic [31:0]             lt_rev;
   logic                    sub_try_out, item_try_out;

   // parallel look-ups over the small subscription table
   always_comb begin
      sub_free_any  = 1'b0;
      sub_free_idx  = '0;
      sub_match_any = 1'b0;
      sub_match_idx = '0;
      sub_taken     = 1'b0;
      sub_cand      = id_first(gen_sub_ff);
      for (int i = SUB_SLOTS - 1; i >= 0; i--) begin
         if (!sub_valid_ff[i]) begin
            sub_free_any = 1'b1;
            sub_free_idx = SUB_IDX_W'(i);
         end
         if (sub_valid_ff[i] && sub_rec_ff[i].session == cur_ff.req.session_no
             && sub_rec_ff[i].ident == cur_ff.req.sub_no) begin
            sub_match_any = 1'b1;
            sub_match_idx = SUB_IDX_W'(i);
         end
         if (sub_valid_ff[i] && sub_rec_ff[i].ident == sub_cand) begin
            sub_taken = 1'b1;
         end
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rd_v         = item_valid_ff[rd_idx_ff];
   assign own_eq       = rd_data_ff.owner == cur_ff.req.sub_no;
   assign hit_alloc    = rd_v && rd_data_ff.ident == cand_ff;
   assign hit_purge    = rd_v && own_eq;
   assign hit_del      = rd_v && own_eq && rd_data_ff.ident == cur_ff.req.item_id;
   assign scan_last    = rd_idx_ff == ITEM_IDX_W'(ITEM_SLOTS - 1);
   assign free_here    = !item_valid_ff[scan_addr_ff[ITEM_IDX_W-1:0]];
   assign free_last    = scan_addr_ff[ITEM_IDX_W-1:0] == ITEM_IDX_W'(ITEM_SLOTS - 1);
   assign ka_rev       = clamp_ka(cur_ff.req.requested_keep_alive);
   assign lt_rev       = raise_lt(cur_ff.req.requested_lifetime, ka_rev);
   assign sub_try_out  = try_ff == TRY_W'(SUB_SLOTS + 1);
   assign item_try_out = try_ff == TRY_W'(ITEM_SLOTS + 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cur_ff.op)
               OP_CREATE:   state_in = sub_free_any ? ST_SUB_DRAW : ST_IDLE;
               OP_DEL_SUB:  state_in = sub_match_any ? ST_SCAN : ST_IDLE;
               OP_ALLOC:    state_in = ST_FREE;
               OP_DEL_ITEM: state_in = ST_SCAN;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_SUB_DRAW: begin
            if (sub_try_out || !sub_taken) state_in = ST_IDLE;
         end
         ST_FREE: begin
            if (free_here) state_in = ST_DRAW;
            else if (free_last) state_in = ST_IDLE;
         end
         ST_DRAW: begin
            state_in = item_try_out ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_live_ff) begin
               priority if (cur_ff.op == OP_ALLOC && hit_alloc) state_in = ST_DRAW;
               else if (cur_ff.op == OP_DEL_ITEM && hit_del) state_in = ST_IDLE;
               else if (scan_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_ready       = 1'b0;
      sub_valid_in  = sub_valid_ff;
      item_valid_in = item_valid_ff;
      gen_sub_in    = gen_sub_ff;
      gen_item_in   = gen_item_ff;
      try_in        = try_ff;
      scan_addr_in  = scan_addr_ff;
      rd_live_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      cand_in       = cand_ff;
      free_item_in  = free_item_ff;
      rsp_load      = 1'b0;
      rsp_in        = '0;
      sub_we        = 1'b0;
      sub_wd        = '0;
      mem_we        = 1'b0;
      mem_wd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = out_free;
         end
         ST_EXEC: begin
            try_in       = '0;
            scan_addr_in = '0;
            unique case (cur_ff.op)
               OP_CREATE: begin
                  if (!sub_free_any) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = STAT_TOO_MANY_SUBS;
                  end
               end
               OP_FIND: begin
                  rsp_load = 1'b1;
                  if (sub_match_any) begin
                     rsp_in.slot_index = SLOT_W'(sub_match_idx);
                  end else begin
                     rsp_in.status = STAT_BAD_SUB;
                  end
               end
               OP_DEL_SUB: begin
                  if (sub_match_any) begin
                     sub_valid_in[sub_match_idx] = 1'b0;
                  end else begin
                     rsp_load      = 1'b1;
                     rsp_in.status = STAT_BAD_SUB;
                  end
               end
               OP_NOP: begin
                  rsp_load = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SUB_DRAW: begin
            if (sub_try_out) begin
               rsp_load      = 1'b1;
               rsp_in.status = STAT_TOO_MANY_SUBS;
            end else begin
               gen_sub_in = id_advance(gen_sub_ff);
               try_in     = try_ff + TRY_W'(1);
               if (!sub_taken) begin
                  sub_we              = 1'b1;
                  sub_wd.ident        = sub_cand;
                  sub_wd.session      = cur_ff.req.session_no;
                  sub_wd.interval     = cur_ff.req.publish_interval;
                  sub_wd.keep_alive   = ka_rev;
                  sub_wd.lifetime     = lt_rev;
                  sub_wd.notify_limit = cur_ff.req.notify_limit;
                  sub_wd.prio         = cur_ff.req.service_priority;
                  sub_wd.publish_on   = cur_ff.req.publish_enable;
                  sub_wd.seq_num      = 32'd1;
                  sub_wd.next_publish = cur_ff.req.now_ms
                                        + {32'd0, cur_ff.req.publish_interval};
                  sub_valid_in[sub_free_idx] = 1'b1;
                  rsp_load                  = 1'b1;
                  rsp_in.slot_index         = SLOT_W'(sub_free_idx);
                  rsp_in.assigned_id        = sub_cand;
                  rsp_in.ka_granted         = ka_rev;
                  rsp_in.lifetime_granted   = lt_rev;
               end
            end
         end
         ST_FREE: begin
            if (free_here) begin
               free_item_in = scan_addr_ff[ITEM_IDX_W-1:0];
               scan_addr_in = '0;
            end else if (free_last) begin
               scan_addr_in  = '0;
               rsp_load      = 1'b1;
               rsp_in.status = STAT_TOO_MANY_ITEMS;
            end else begin
               scan_addr_in = scan_addr_ff + ITEM_CNT_W'(1);
            end
         end
         ST_DRAW: begin
            scan_addr_in = '0;
            if (item_try_out) begin
               rsp_load      = 1'b1;
               rsp_in.status = STAT_TOO_MANY_ITEMS;
            end else begin
               cand_in     = id_first(gen_item_ff);
               gen_item_in = id_advance(gen_item_ff);
               try_in      = try_ff + TRY_W'(1);
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous one is checked
            if (!scan_addr_ff[ITEM_IDX_W]) begin
               rd_live_in   = 1'b1;
               rd_idx_in    = scan_addr_ff[ITEM_IDX_W-1:0];
               scan_addr_in = scan_addr_ff + ITEM_CNT_W'(1);
            end
            if (rd_live_ff) begin
               unique case (cur_ff.op)
                  OP_ALLOC: begin
                     if (hit_alloc) begin
                        rd_live_in   = 1'b0;
                        scan_addr_in = '0;
                     end else if (scan_last) begin
                        rd_live_in                  = 1'b0;
                        scan_addr_in                = '0;
                        mem_we                      = 1'b1;
                        mem_wd.owner                = cur_ff.req.sub_no;
                        mem_wd.ident                = cand_ff;
                        item_valid_in[free_item_ff] = 1'b1;
                        rsp_load                    = 1'b1;
                        rsp_in.slot_index           = SLOT_W'(free_item_ff);
                        rsp_in.assigned_id          = cand_ff;
                     end
                  end
                  OP_DEL_ITEM: begin
                     if (hit_del) begin
                        item_valid_in[rd_idx_ff] = 1'b0;
                        rd_live_in               = 1'b0;
                        scan_addr_in             = '0;
                        rsp_load                 = 1'b1;
                     end else if (scan_last) begin
                        rd_live_in    = 1'b0;
                        scan_addr_in  = '0;
                        rsp_load      = 1'b1;
                        rsp_in.status = STAT_BAD_ITEM;
                     end
                  end
                  default: begin
                     if (hit_purge) item_valid_in[rd_idx_ff] = 1'b0;
                     if (scan_last) begin
                        rd_live_in   = 1'b0;
                        scan_addr_in = '0;
                        rsp_load     = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sub_valid_ff  <= '0;
         item_valid_ff <= '0;
         gen_sub_ff    <= 32'd1;
         gen_item_ff   <= 32'd1;
         try_ff        <= '0;
         scan_addr_ff  <= '0;
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sub_valid_ff  <= sub_valid_in;
         item_valid_ff <= item_valid_in;
         gen_sub_ff    <= gen_sub_in;
         gen_item_ff   <= gen_item_in;
         try_ff        <= try_in;
         scan_addr_ff  <= scan_addr_in;
         rd_live_ff    <= rd_live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) cur_ff <= q_data;
      if (sub_we) sub_rec_ff[sub_free_idx] <= sub_wd;
      if (rsp_load) rsp_ff <= rsp_in;
      rd_idx_ff    <= rd_idx_in;
      cand_ff      <= cand_in;
      free_item_ff <= free_item_in;
   end

   // item table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) item_mem[free_item_ff] <= mem_wd;
      rd_data_ff <= item_mem[scan_addr_ff[ITEM_IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "subscription_slot_table_assert.svh"

   `SST_ASSERT_NOW(a_pop_only_idle, clock, reset, q_valid && q_ready,
      state_ff == ST_IDLE, "command taken outside idle")
   `SST_ASSERT_NEXT(a_pop_to_exec, clock, reset, q_valid && q_ready,
      state_ff == ST_EXEC, "taken command not executed")
   `SST_ASSERT_NOW(a_no_result_overwrite, clock, reset, rsp_load,
      !rsp_valid_ff || rsp_ready, "result register overwritten")
   `SST_ASSERT_NOW(a_try_bound, clock, reset, 1'b1,
      try_ff <= TRY_W'(ITEM_SLOTS + 1), "id draw count out of range")

endmodule

// ===== rtl/core/subscription_slot_table.sv =====
// top level of the subscription slot table
// usage: one request in, exactly one response out, in order. a 2-deep command
// queue sits in front of the engine and a response register behind it, so a
// request can be taken while the previous response still waits. commands run
// one at a time in the engine: find and unknown codes answer from the exec
// state, create checks one id candidate at a time (at most 8 for 8 slots, as
// at most seven ids are in use while a slot is free), delete subscription
// sweeps the 64-entry item memory, delete item stops at the first match, and
// allocate item first walks the valid bits for a free slot then checks each
// id candidate against the item memory at one read per cycle, at most 64
// candidates since at most 63 ids are in use while a slot is free. the single
// read port of the item memory makes these sweeps go entry by entry.
// no clearing pass is needed after reset: valid bits live in flip-flops.
module subscription_slot_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sst_pkg::rsp_type rsp_data
);
   import sst_pkg::*;

   // queue between intake and engine
   logic     q_valid;
   logic     q_ready;
   work_type q_data;

   // intake: decode and buffer requests
   sst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   // engine: tables, generators and response register
   sst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
